[design/ataps_pkg.sv]
package ataps_pkg;

  // Field widths of the request and result
  localparam int unsigned CountW = 7;
  localparam int unsigned IdW    = 6;

  // Default largest node count
  localparam int unsigned MaxNodesDefault = 64;

  // Request: node count and this node's id
  typedef struct packed {
    logic [CountW-1:0] node_count;
    logic [IdW-1:0]    node_id;
  } req_t;

  // Result: one schedule slot
  typedef struct packed {
    logic [IdW-1:0] partner;
    logic           last_slot;
    logic           bad_request;
  } rsp_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture a new request
    logic step;  // produce the next slot into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;  // the slot produced on step is the final one
  } sts_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

endpackage

[design/ataps_ctrl.sv]
module ataps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ataps_pkg::cmd_t     cmd_o,
  input  ataps_pkg::sts_t     sts_i
);

  ataps_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              can_step;

  // Output register is free when empty or being drained this cycle
  assign can_step = !out_valid_q || out_ready_i;

  // Sequence one request at a time
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    unique case (state_q)
      ataps_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ataps_pkg::StRun;
        end
      end
      ataps_pkg::StRun: begin
        if (can_step) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = ataps_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = ataps_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ataps_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ataps_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[design/ataps_dp.sv]
module ataps_dp #(
  parameter int unsigned MAX_NODES = ataps_pkg::MaxNodesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ataps_pkg::req_t    req_i,
  input  ataps_pkg::cmd_t    cmd_i,
  output ataps_pkg::sts_t    sts_o,
  output ataps_pkg::rsp_t    rsp_o
);

  localparam int unsigned CW = ataps_pkg::CountW;
  localparam int unsigned IW = ataps_pkg::IdW;

  // Held request and slot sequencer
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] id_q, id_d;
  logic          bad_q, bad_d;
  logic          self_q, self_d;
  logic [IW-1:0] pe_q, pe_d;
  logic [CW-1:0] rem_q, rem_d;
  ataps_pkg::rsp_t out_q, out_d;

  // Round arithmetic
  logic          even;
  logic [CW-1:0] m, half, pe_w, id_w, cnt_m1;
  logic [CW-1:0] i1_raw, i1, i2_raw, i2, p1_raw, p1, p2_raw, p2;
  logic [IW-1:0] pair_partner, slot_partner;

  assign even   = !cnt_q[0];
  assign cnt_m1 = cnt_q - CW'(1);
  assign m      = even ? cnt_m1 : cnt_q;
  assign half   = even ? (cnt_q >> 1) : ((cnt_q + CW'(1)) >> 1);
  assign pe_w   = CW'(pe_q);
  assign id_w   = CW'(id_q);

  // Offsets of this node from the round's center, reduced mod m
  assign i1_raw = pe_w - id_w + m;
  assign i1     = (i1_raw >= m) ? i1_raw - m : i1_raw;
  assign i2_raw = id_w - pe_w + m;
  assign i2     = (i2_raw >= m) ? i2_raw - m : i2_raw;
  assign p1_raw = pe_w + i1;
  assign p1     = (p1_raw >= m) ? p1_raw - m : p1_raw;
  assign p2_raw = pe_w - i2 + m;
  assign p2     = (p2_raw >= m) ? p2_raw - m : p2_raw;

  assign pair_partner = (i1 < half) ? p1[IW-1:0] : p2[IW-1:0];

  // Pick the partner of the current round
  always_comb begin
    priority if (pe_q == id_q) begin
      slot_partner = even ? cnt_m1[IW-1:0] : pe_q;
    end else if (even && (cnt_m1 == id_w)) begin
      slot_partner = pe_q;
    end else begin
      slot_partner = pair_partner;
    end
  end

  assign sts_o.last = bad_q || (rem_q == CW'(1));

  // Load a request, or emit a slot and advance
  always_comb begin
    cnt_d  = cnt_q;
    id_d   = id_q;
    bad_d  = bad_q;
    self_d = self_q;
    pe_d   = pe_q;
    rem_d  = rem_q;
    out_d  = out_q;
    if (cmd_i.load) begin
      cnt_d  = req_i.node_count;
      id_d   = req_i.node_id;
      bad_d  = (CW'(req_i.node_id) >= req_i.node_count)
            || (32'(req_i.node_count) > MAX_NODES);
      self_d = !req_i.node_count[0];
      pe_d   = '0;
      rem_d  = req_i.node_count;
    end else if (cmd_i.step) begin
      out_d.last_slot   = sts_o.last;
      out_d.bad_request = bad_q;
      if (bad_q) begin
        out_d.partner = '0;
      end else if (self_q) begin
        out_d.partner = id_q;
      end else begin
        out_d.partner = slot_partner;
      end
      if (self_q) begin
        self_d = 1'b0;
      end else begin
        pe_d = pe_q + IW'(1);
      end
      rem_d = rem_q - CW'(1);
    end
  end

  // Control flags need reset; payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q  <= 1'b0;
      self_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      bad_q  <= bad_d;
      self_q <= self_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    id_q  <= id_d;
    pe_q  <= pe_d;
    out_q <= out_d;
  end

  assign rsp_o = out_q;

endmodule

[design/all_to_all_partner_schedule_top.sv]
// Round-robin partner schedule. Each request carries a node count N and this
// node's id; the block returns N results, one per schedule slot, naming the
// node to exchange with in that slot, with last_slot set on the final one.
// Every node meets itself once: for an even count the self slot comes first
// and node N-1 is the fixed pivot; an odd count runs with a virtual extra node
// that never appears. An id not below the count, or a count above MAX_NODES,
// gives one result with partner 0 and bad_request set. A request is captured
// while the block is idle; the slot sequencer then gives one slot per cycle
// while the output register is free or being drained, and its round
// arithmetic resolves each slot combinationally. A new request is taken
// while the final result still waits in the output register.
module all_to_all_partner_schedule_top #(
  parameter int unsigned MAX_NODES = ataps_pkg::MaxNodesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ataps_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ataps_pkg::rsp_t  out_rsp_o
);

  ataps_pkg::cmd_t cmd;
  ataps_pkg::sts_t sts;

  // Sequence requests and handshakes
  ataps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the request and compute each slot's partner
  ataps_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

[bench/all_to_all_partner_schedule_top_tb.sv]
`timescale 1ns / 100ps

module all_to_all_partner_schedule_top_tb;

  localparam int unsigned MAX_NODES     = 64;
  localparam int          IdlePercent   = 23;
  localparam int          RxHoldCycles  = 300;
  localparam int          WatchdogLimit = 3000;
  localparam int          TailCycles    = 80;

  logic            clk;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  ataps_pkg::req_t in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  ataps_pkg::rsp_t out_rsp_o;

  // Requests waiting to be offered, slots still owed by the block
  ataps_pkg::req_t pending_reqs[$];
  ataps_pkg::rsp_t exp_slots[$];

  bit   req_taken    = 1'b0;
  bit   quiet_run    = 1'b0;
  bit   rx_hold_go   = 1'b0;
  bit   rx_hold_seen = 1'b0;
  int   rx_hold_left = 0;
  int   stall_cycles = 0;
  int   fail_cnt     = 0;

  all_to_all_partner_schedule_top #(
    .MAX_NODES(MAX_NODES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // a mod m for 0 <= a < 2m
  function automatic int wrap_mod(input int a, input int m);
    return (a >= m) ? a - m : a;
  endfunction

  // Expand one request into the tournament slots it should produce
  function automatic void predict_schedule(input ataps_pkg::req_t r);
    int              cnt;
    int              id;
    int              n;
    int              m;
    int              i;
    bit              even;
    int              partners[$];
    ataps_pkg::rsp_t slot;
    cnt = r.node_count;
    id  = r.node_id;
    if (id >= cnt || cnt > MAX_NODES) begin
      slot.partner     = '0;
      slot.last_slot   = 1'b1;
      slot.bad_request = 1'b1;
      exp_slots.push_back(slot);
      return;
    end
    even = (cnt % 2) == 0;
    n    = even ? cnt : cnt + 1;
    m    = n - 1;
    // even count: self slot comes first, node cnt-1 is the pivot
    if (even) partners.push_back(id);
    for (int pe = 0; pe < m; pe++) begin
      if (even) begin
        if (pe == id) partners.push_back(cnt - 1);
        else if (cnt - 1 == id) partners.push_back(pe);
      end else if (pe == id) begin
        partners.push_back(pe);
      end
      if (pe != id && id < m) begin
        i = wrap_mod(pe - id + m, m);
        if (i < n / 2) partners.push_back(wrap_mod(pe + i, m));
        i = wrap_mod(id - pe + m, m);
        if (i < n / 2) partners.push_back(wrap_mod(pe - i + m, m));
      end
    end
    for (int k = 0; k < partners.size() && k < MAX_NODES; k++) begin
      slot.partner     = partners[k][ataps_pkg::IdW-1:0];
      slot.last_slot   = (k == partners.size() - 1 || k == MAX_NODES - 1);
      slot.bad_request = 1'b0;
      exp_slots.push_back(slot);
    end
  endfunction

  task automatic push_req(input int cnt, input int id);
    ataps_pkg::req_t r;
    r.node_count = cnt[ataps_pkg::CountW-1:0];
    r.node_id    = id[ataps_pkg::IdW-1:0];
    pending_reqs.push_back(r);
  endtask

  // Mostly small well-formed requests, a few large ones, some rejects
  task automatic push_random_req();
    int sel;
    int cnt;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      push_req($urandom_range(65, 127), $urandom_range(0, 63));
    end else if (sel < 14) begin
      cnt = $urandom_range(0, 63);
      push_req(cnt, $urandom_range(cnt, 63));
    end else if (sel < 24) begin
      cnt = $urandom_range(33, 64);
      push_req(cnt, $urandom_range(0, cnt - 1));
    end else begin
      cnt = $urandom_range(1, 16);
      push_req(cnt, $urandom_range(0, cnt - 1));
    end
  endtask

  // Hold until every request is taken and every slot has come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || exp_slots.size() != 0)
      @(posedge clk);
  endtask

  task automatic note_fail(input string msg);
    if (fail_cnt < 10) $display("%0t: %s", $time, msg);
    fail_cnt++;
  endtask

  // Request driver: advance on acceptance, insert random gaps
  always @(negedge clk) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 &&
          (quiet_run || $urandom_range(0, 99) >= IdlePercent)) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (rx_hold_go != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_go;
      rx_hold_left <= RxHoldCycles;
      out_ready_i  <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= quiet_run || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Monitor: predict on each request, check each slot, watch for hangs
  always @(posedge clk) begin
    ataps_pkg::rsp_t want;
    req_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_schedule(in_req_i);
      if (out_valid_o && out_ready_i) begin
        if (exp_slots.size() == 0) begin
          note_fail($sformatf("unexpected slot partner=%0d last=%0b bad=%0b",
                              out_rsp_o.partner, out_rsp_o.last_slot,
                              out_rsp_o.bad_request));
        end else begin
          want = exp_slots.pop_front();
          if (out_rsp_o.partner !== want.partner ||
              out_rsp_o.last_slot !== want.last_slot ||
              out_rsp_o.bad_request !== want.bad_request)
            note_fail($sformatf(
              "slot mismatch: partner exp %0d got %0d, last exp %0b got %0b, bad exp %0b got %0b",
              want.partner, out_rsp_o.partner, want.last_slot, out_rsp_o.last_slot,
              want.bad_request, out_rsp_o.bad_request));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: single node, empty and oversized counts, bad ids, extremes
    push_req(1, 0);
    push_req(0, 0);
    push_req(2, 0);
    push_req(2, 1);
    push_req(3, 0);
    push_req(3, 1);
    push_req(3, 2);
    push_req(4, 3);
    push_req(5, 4);
    push_req(64, 0);
    push_req(64, 63);
    push_req(63, 62);
    push_req(64, 31);
    push_req(65, 0);
    push_req(127, 63);
    push_req(100, 5);
    push_req(10, 10);
    push_req(10, 63);
    push_req(1, 1);
    push_req(7, 3);
    push_req(6, 2);
    push_req(8, 7);
    wait_drained();

    // Back-to-back stretch with neither side idling
    quiet_run = 1'b1;
    repeat (30) push_random_req();
    wait_drained();
    quiet_run = 1'b0;

    // Receiver holds off while requests keep coming
    rx_hold_go = ~rx_hold_go;
    repeat (8) push_req(16, $urandom_range(0, 15));
    wait_drained();

    repeat (40) push_random_req();
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0 && exp_slots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[all_to_all_partner_schedule_top.f]
design/ataps_pkg.sv
design/ataps_ctrl.sv
design/ataps_dp.sv
design/all_to_all_partner_schedule_top.sv
bench/all_to_all_partner_schedule_top_tb.sv
